@@ sv/mur_pkg.sv @@
// ----------------------------------------------------------------------------
// mur_pkg: shared constants of the multichannel ultrasonic ranger
// Field widths, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package mur_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 4;

  localparam int unsigned CHAN_W   = 2;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned ECHO_W   = 3;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned DIST_W   = 35;
  localparam int unsigned PROD_W   = COUNT_W + SCALE_W;
  localparam int unsigned FRAC_SH  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_ON    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_OFF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd4;

  localparam logic [LIMIT_W-1:0] TRIG_ON_RST    = 16'd10;
  localparam logic [LIMIT_W-1:0] TRIG_OFF_RST   = 16'd20;
  localparam logic [COUNT_W-1:0] PERIOD_RST     = 32'd1000;
  localparam logic [ECHO_W-1:0]  ECHO_LIMIT_RST = 3'd3;
  localparam logic [SCALE_W-1:0] SCALE_RST      = 24'd285213;

  localparam logic [ECHO_W-1:0] ECHO_SAT = 3'd7;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_EDGE = 1'b1;

endpackage

`default_nettype wire

@@ sv/multichannel_ultrasonic_ranger.sv @@
// ----------------------------------------------------------------------------
// multichannel_ultrasonic_ranger: time-of-flight ranging over echo channels
// Counts microsecond ticks, drives the shared trigger, stamps rising echo
// edges and turns falling edges into Q8 centimetre distances.
// ----------------------------------------------------------------------------
//
//   port group   direction   handshake               payload
//   in           sink        in_valid_i / in_stall_o   req_type, channel, echo_level
//   out          source      out_valid_o / out_stall_i trigger, distance, restart flags
//   cfg          sink        cfg_we_i                  cfg_index_i, cfg_data_i
//
// One word per cycle sustained unless the output stalls; a word passes the input
// register, then the result register fed by one 32x24 multiply and counter compares.
// Reset clears the counters, stamps and trigger and loads register defaults.
// An output stall holds the result register; the input register still takes
// one more word, then in_stall_o rises until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_ultrasonic_ranger #(
  parameter int unsigned NUM_CHANNELS = mur_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,

  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             req_type_i,
  input  wire logic [mur_pkg::CHAN_W-1:0]       channel_i,
  input  wire logic                             echo_level_i,

  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  trigger_out_o,
  output logic                                  distance_valid_o,
  output logic [mur_pkg::CHAN_W-1:0]            distance_channel_o,
  output logic [mur_pkg::DIST_W-1:0]            distance_q8_o,
  output logic                                  cycle_restarted_o,

  input  wire logic                             cfg_we_i,
  input  wire logic [mur_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [mur_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import mur_pkg::*;

  localparam int unsigned SHIFT_W = PROD_W - FRAC_SH;

  // configuration
  logic [LIMIT_W-1:0] trig_on_q, trig_off_q;
  logic [COUNT_W-1:0] period_q;
  logic [ECHO_W-1:0]  echo_limit_q;
  logic [SCALE_W-1:0] scale_q;

  // input register
  logic              s1_valid_q;
  logic              s1_type_q;
  logic [CHAN_W-1:0] s1_chan_q;
  logic              s1_level_q;

  // ranging state
  logic [COUNT_W-1:0] tick_q, tick_d;
  logic               trig_q, trig_d;
  logic [ECHO_W-1:0]  echoes_q, echoes_d;
  logic [COUNT_W-1:0] stamp_q [NUM_CHANNELS];

  // result register
  logic              out_valid_q;
  logic              res_trig_q;
  logic              res_dvalid_q, res_dvalid_d;
  logic [CHAN_W-1:0] res_chan_q, res_chan_d;
  logic [DIST_W-1:0] res_dist_q, res_dist_d;
  logic              res_restart_q, res_restart_d;

  logic               out_ready;
  logic               s1_fire;
  logic               in_accept;
  logic               chan_ok;
  logic               stamp_we;
  logic [COUNT_W-1:0] tick_inc;
  logic [COUNT_W-1:0] stamp_sel;
  logic [COUNT_W-1:0] elapsed;
  logic [PROD_W-1:0]  prod;
  logic [SHIFT_W-1:0] prod_sh;
  logic [ECHO_W-1:0]  echoes_inc;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_on_q    <= TRIG_ON_RST;
      trig_off_q   <= TRIG_OFF_RST;
      period_q     <= PERIOD_RST;
      echo_limit_q <= ECHO_LIMIT_RST;
      scale_q      <= SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TRIG_ON:    trig_on_q    <= cfg_data_i[LIMIT_W-1:0];
        CFG_TRIG_OFF:   trig_off_q   <= cfg_data_i[LIMIT_W-1:0];
        CFG_PERIOD:     period_q     <= cfg_data_i[COUNT_W-1:0];
        CFG_ECHO_LIMIT: echo_limit_q <= cfg_data_i[ECHO_W-1:0];
        CFG_SCALE:      scale_q      <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_type_q  <= req_type_i;
      s1_chan_q  <= channel_i;
      s1_level_q <= echo_level_i;
    end
  end

  always_comb begin
    stamp_sel = '0;
    for (int i = 0; i < int'(NUM_CHANNELS); i++) begin
      if (int'(s1_chan_q) == i) begin
        stamp_sel = stamp_q[i];
      end
    end
  end

  assign chan_ok    = int'(s1_chan_q) < int'(NUM_CHANNELS);
  assign tick_inc   = tick_q + COUNT_W'(1);
  assign elapsed    = tick_q - stamp_sel;
  assign prod       = PROD_W'(elapsed) * PROD_W'(scale_q);
  assign prod_sh    = prod[PROD_W-1:FRAC_SH];
  assign echoes_inc = (echoes_q < ECHO_SAT) ? echoes_q + ECHO_W'(1) : echoes_q;

  always_comb begin
    tick_d        = tick_q;
    trig_d        = trig_q;
    echoes_d      = echoes_q;
    stamp_we      = 1'b0;
    res_dvalid_d  = 1'b0;
    res_chan_d    = '0;
    res_dist_d    = '0;
    res_restart_d = 1'b0;
    if (s1_type_q == REQ_TICK) begin
      tick_d = tick_inc;
      if (tick_inc < COUNT_W'(trig_on_q)) begin
        trig_d = 1'b1;
      end else if (tick_inc >= COUNT_W'(trig_off_q)) begin
        trig_d = 1'b0;
      end
      if (int'(echoes_q) < int'(NUM_CHANNELS) && tick_inc >= period_q) begin
        tick_d        = '0;
        echoes_d      = '0;
        res_restart_d = 1'b1;
      end
    end else if (chan_ok) begin
      if (s1_level_q) begin
        stamp_we = 1'b1;
      end else begin
        res_dvalid_d = 1'b1;
        res_chan_d   = s1_chan_q;
        res_dist_d   = (|prod_sh[SHIFT_W-1:DIST_W]) ? '1 : prod_sh[DIST_W-1:0];
        echoes_d     = echoes_inc;
        if (echoes_inc >= echo_limit_q) begin
          tick_d        = '0;
          echoes_d      = '0;
          res_restart_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      trig_q   <= 1'b0;
      echoes_q <= '0;
      for (int i = 0; i < int'(NUM_CHANNELS); i++) begin
        stamp_q[i] <= '0;
      end
    end else if (s1_fire) begin
      tick_q   <= tick_d;
      trig_q   <= trig_d;
      echoes_q <= echoes_d;
      for (int i = 0; i < int'(NUM_CHANNELS); i++) begin
        if (stamp_we && int'(s1_chan_q) == i) begin
          stamp_q[i] <= tick_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_trig_q    <= trig_d;
      res_dvalid_q  <= res_dvalid_d;
      res_chan_q    <= res_chan_d;
      res_dist_q    <= res_dist_d;
      res_restart_q <= res_restart_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign trigger_out_o      = res_trig_q;
  assign distance_valid_o   = res_dvalid_q;
  assign distance_channel_o = res_chan_q;
  assign distance_q8_o      = res_dist_q;
  assign cycle_restarted_o  = res_restart_q;

endmodule

`default_nettype wire

@@ sv/mur_checker.sv @@
// ----------------------------------------------------------------------------
// mur_checker: port-level checks for the ultrasonic ranger
// Watches the handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mur_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic                       trigger_out_o,
  input wire logic                       distance_valid_o,
  input wire logic [mur_pkg::CHAN_W-1:0] distance_channel_o,
  input wire logic [mur_pkg::DIST_W-1:0] distance_q8_o,
  input wire logic                       cycle_restarted_o
);

  import mur_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(trigger_out_o)
      && $stable(distance_valid_o) && $stable(distance_channel_o)
      && $stable(distance_q8_o) && $stable(cycle_restarted_o))
    else $error("stalled result word changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !distance_valid_o |-> distance_q8_o == '0 && distance_channel_o == '0)
    else $error("distance fields set without a measurement");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result path is free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result word without an accepted input word");

endmodule

bind multichannel_ultrasonic_ranger mur_checker u_mur_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .trigger_out_o      (trigger_out_o),
  .distance_valid_o   (distance_valid_o),
  .distance_channel_o (distance_channel_o),
  .distance_q8_o      (distance_q8_o),
  .cycle_restarted_o  (cycle_restarted_o)
);

`default_nettype wire

@@ dv/mur_distance_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mur_distance_checker: ranging predictor and result comparison
// Follows every accepted input word and register write, predicts the trigger
// level, distance flag and channel, distance and restart flag of each word,
// and compares them field by field with the ranger's result words, in order.
// ----------------------------------------------------------------------------

module mur_distance_checker
  import mur_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  req_type_i,
  input  logic [CHAN_W-1:0]     channel_i,
  input  logic                  echo_level_i,

  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  trigger_out_i,
  input  logic                  distance_valid_i,
  input  logic [CHAN_W-1:0]     distance_channel_i,
  input  logic [DIST_W-1:0]     distance_q8_i,
  input  logic                  cycle_restarted_i,

  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    distances_o,
  output int                    saturated_o,
  output int                    restarts_o
);

  typedef struct packed {
    logic              trig;
    logic              dvalid;
    logic [CHAN_W-1:0] dch;
    logic [DIST_W-1:0] distance;
    logic              restart;
  } ranging_t;

  localparam logic [PROD_W-1:0] DIST_CEIL = {{(PROD_W-DIST_W){1'b0}}, {DIST_W{1'b1}}};

  logic [LIMIT_W-1:0] on_lim;
  logic [LIMIT_W-1:0] off_lim;
  logic [COUNT_W-1:0] period;
  logic [ECHO_W-1:0]  echo_lim;
  logic [SCALE_W-1:0] scale;

  logic [COUNT_W-1:0] ticks;
  logic               trig_level;
  logic [COUNT_W-1:0] rise_at [NUM_CHANNELS_DEF];
  logic [ECHO_W-1:0]  echoes;

  ranging_t ranging_q [$];
  int fails, checked, dists, sats, restarts;

  function automatic ranging_t advance_ranger(logic rt, logic [CHAN_W-1:0] ch, logic lvl);
    ranging_t           r;
    logic               restart;
    logic [COUNT_W-1:0] elapsed;
    logic [PROD_W-1:0]  prod;
    r = '0;
    restart = 1'b0;
    if (rt == REQ_TICK) begin
      ticks = ticks + COUNT_W'(1);
      if (ticks < COUNT_W'(on_lim)) begin
        trig_level = 1'b1;
      end else if (ticks >= COUNT_W'(off_lim)) begin
        trig_level = 1'b0;
      end
      restart = (int'(echoes) < NUM_CHANNELS_DEF) && (ticks >= period);
    end else if (lvl) begin
      rise_at[ch] = ticks;
    end else begin
      elapsed = ticks - rise_at[ch];
      prod = ({{(PROD_W-COUNT_W){1'b0}}, elapsed} * {{(PROD_W-SCALE_W){1'b0}}, scale})
             >> FRAC_SH;
      r.distance = (prod > DIST_CEIL) ? {DIST_W{1'b1}} : prod[DIST_W-1:0];
      r.dvalid   = 1'b1;
      r.dch      = ch;
      if (echoes != ECHO_SAT) begin
        echoes = echoes + ECHO_W'(1);
      end
      restart = (echoes >= echo_lim);
    end
    if (restart) begin
      ticks  = '0;
      echoes = '0;
    end
    r.restart = restart;
    r.trig    = trig_level;
    return r;
  endfunction

  task automatic check_field(string field, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ranging_t want;
    if (!rst_ni) begin
      on_lim     = TRIG_ON_RST;
      off_lim    = TRIG_OFF_RST;
      period     = PERIOD_RST;
      echo_lim   = ECHO_LIMIT_RST;
      scale      = SCALE_RST;
      ticks      = '0;
      trig_level = 1'b0;
      echoes     = '0;
      for (int c = 0; c < NUM_CHANNELS_DEF; c++) begin
        rise_at[c] = '0;
      end
      ranging_q.delete();
      fails    = 0;
      checked  = 0;
      dists    = 0;
      sats     = 0;
      restarts = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TRIG_ON:    on_lim   = cfg_data_i[LIMIT_W-1:0];
          CFG_TRIG_OFF:   off_lim  = cfg_data_i[LIMIT_W-1:0];
          CFG_PERIOD:     period   = cfg_data_i[COUNT_W-1:0];
          CFG_ECHO_LIMIT: echo_lim = cfg_data_i[ECHO_W-1:0];
          CFG_SCALE:      scale    = cfg_data_i[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (ranging_q.size() == 0) begin
          $error("result word with no expectation waiting");
          fails++;
        end else begin
          want = ranging_q.pop_front();
          check_field("trigger_out", DIST_W'(want.trig), DIST_W'(trigger_out_i));
          check_field("distance_valid", DIST_W'(want.dvalid), DIST_W'(distance_valid_i));
          check_field("distance_channel", DIST_W'(want.dch), DIST_W'(distance_channel_i));
          check_field("distance_q8", want.distance, distance_q8_i);
          check_field("cycle_restarted", DIST_W'(want.restart), DIST_W'(cycle_restarted_i));
          checked++;
          if (want.dvalid) dists++;
          if (want.dvalid && want.distance == {DIST_W{1'b1}}) sats++;
          if (want.restart) restarts++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        ranging_q.push_back(advance_ranger(req_type_i, channel_i, echo_level_i));
      end
    end
    fail_count_o <= fails;
    pending_o    <= ranging_q.size();
    checked_o    <= checked;
    distances_o  <= dists;
    saturated_o  <= sats;
    restarts_o   <= restarts;
  end

endmodule

@@ dv/multichannel_ultrasonic_ranger_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multichannel_ultrasonic_ranger_tb: stimulus and verdict for the ranger
// Drives tick and echo edge words over all four channels with random input
// and output idling outside steady phases, rewrites registers between phases,
// and leaves prediction and comparison to the distance checker by the ranger.
// ----------------------------------------------------------------------------

module multichannel_ultrasonic_ranger_tb;
  import mur_pkg::*;

  localparam int unsigned IDLE_MAX        = 13;
  localparam int unsigned HOLD_CYCLES     = 80;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned WORDS_PER_PHASE = 117;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam logic        LVL_RISE        = 1'b1;
  localparam logic        LVL_FALL        = 1'b0;

  typedef struct {
    logic [LIMIT_W-1:0] on_lim;
    logic [LIMIT_W-1:0] off_lim;
    logic [COUNT_W-1:0] period;
    logic [ECHO_W-1:0]  echo_lim;
    logic [SCALE_W-1:0] scale;
    bit                 steady;
    bit                 long_hold;
    bit                 mid_drain;
  } setting_t;

  logic                  clk_i              = 1'b0;
  logic                  rst_ni             = 1'b0;
  logic                  in_valid_i         = 1'b0;
  logic                  in_stall_o;
  logic                  req_type_i         = REQ_TICK;
  logic [CHAN_W-1:0]     channel_i          = '0;
  logic                  echo_level_i       = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i        = 1'b0;
  logic                  trigger_out_o;
  logic                  distance_valid_o;
  logic [CHAN_W-1:0]     distance_channel_o;
  logic [DIST_W-1:0]     distance_q8_o;
  logic                  cycle_restarted_o;
  logic                  cfg_we_i           = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i        = CFG_TRIG_ON;
  logic [CFG_DATA_W-1:0] cfg_data_i         = '0;

  int fail_count, pending, checked, distances, saturated, restarts;
  int settings_used = 0;
  int idle_cycles   = 0;
  bit steady        = 1'b0;
  bit hold_req      = 1'b0;
  logic pin_high [NUM_CHANNELS_DEF] = '{default: 1'b0};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  multichannel_ultrasonic_ranger u_top (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .req_type_i, .channel_i, .echo_level_i,
    .out_valid_o, .out_stall_i, .trigger_out_o, .distance_valid_o,
    .distance_channel_o, .distance_q8_o, .cycle_restarted_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  mur_distance_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .channel_i, .echo_level_i,
    .out_valid_i(out_valid_o), .out_stall_i, .trigger_out_i(trigger_out_o),
    .distance_valid_i(distance_valid_o), .distance_channel_i(distance_channel_o),
    .distance_q8_i(distance_q8_o), .cycle_restarted_i(cycle_restarted_o),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked),
    .distances_o(distances), .saturated_o(saturated), .restarts_o(restarts)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned wait_cycles;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      wait_cycles = steady ? 0 : $urandom_range(0, IDLE_MAX);
      if (wait_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_word(logic rt, logic [CHAN_W-1:0] ch, logic lvl);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= rt;
    channel_i    <= ch;
    echo_level_i <= lvl;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_random_word();
    int unsigned       pick;
    logic              rt;
    logic [CHAN_W-1:0] ch;
    logic              lvl;
    pick = $urandom_range(0, 99);
    ch   = CHAN_W'($urandom_range(0, NUM_CHANNELS_DEF - 1));
    if (pick < 55) begin
      rt  = REQ_TICK;
      lvl = 1'($urandom_range(0, 1));
    end else begin
      rt  = REQ_EDGE;
      lvl = ($urandom_range(0, 4) == 0) ? 1'($urandom_range(0, 1)) : !pin_high[ch];
      pin_high[ch] = lvl;
    end
    send_word(rt, ch, lvl);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
  endtask

  task automatic load_settings(setting_t s);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_TRIG_ON, CFG_DATA_W'(s.on_lim));
    write_reg(CFG_TRIG_OFF, CFG_DATA_W'(s.off_lim));
    write_reg(CFG_PERIOD, CFG_DATA_W'(s.period));
    write_reg(CFG_ECHO_LIMIT, CFG_DATA_W'(s.echo_lim));
    write_reg(CFG_SCALE, CFG_DATA_W'(s.scale));
    cfg_we_i <= 1'b0;
    steady   = s.steady;
    hold_req = s.long_hold;
    settings_used++;
  endtask

  initial begin
    setting_t plan [NUM_PHASES];
    setting_t warmup;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    warmup = '{16'd2, 16'd4, PERIOD_RST, ECHO_LIMIT_RST, 24'hFF_FFFF, 1'b0, 1'b0, 1'b0};
    load_settings(warmup);
    repeat (4) send_word(REQ_TICK, 2'd3, LVL_RISE);
    send_word(REQ_EDGE, 2'd0, LVL_RISE);
    send_word(REQ_EDGE, 2'd1, LVL_FALL);
    send_word(REQ_EDGE, 2'd3, LVL_RISE);
    send_word(REQ_TICK, 2'd0, LVL_FALL);
    send_word(REQ_EDGE, 2'd3, LVL_FALL);
    send_word(REQ_EDGE, 2'd2, LVL_FALL);
    send_word(REQ_EDGE, 2'd0, LVL_FALL);
    send_word(REQ_EDGE, 2'd1, LVL_RISE);
    send_word(REQ_EDGE, 2'd1, LVL_FALL);

    plan[0] = '{TRIG_ON_RST, TRIG_OFF_RST, PERIOD_RST, ECHO_LIMIT_RST, SCALE_RST,
                1'b0, 1'b0, 1'b0};
    plan[1] = '{16'd0, 16'd0, 32'd0, 3'd0, 24'd0, 1'b0, 1'b0, 1'b0};
    plan[2] = '{16'hFFFF, 16'd0, 32'hFFFF_FFFF, 3'd7, 24'hFF_FFFF, 1'b1, 1'b1, 1'b0};
    plan[3] = '{16'd20, 16'd5, 32'd30, 3'd1, 24'($urandom), 1'b0, 1'b0, 1'b1};
    plan[4] = '{16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                32'($urandom_range(1, 80)), 3'($urandom), 24'($urandom), 1'b0, 1'b0, 1'b0};
    plan[5] = '{16'd0, 16'hFFFF, 32'd15, 3'd4, 24'd1, 1'b1, 1'b0, 1'b0};
    plan[6] = '{16'd3, 16'd8, 32'd10, 3'd5, 24'($urandom), 1'b0, 1'b0, 1'b0};
    plan[7] = '{16'($urandom), 16'($urandom), 32'($urandom), 3'($urandom), 24'($urandom),
                1'b0, 1'b0, 1'b0};

    for (int p = 0; p < NUM_PHASES; p++) begin
      load_settings(plan[p]);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if (plan[p].mid_drain && i == WORDS_PER_PHASE / 2) begin
          drain();
        end
        send_random_word();
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("tb: %0d result words checked over %0d register settings", checked, settings_used);
    $display("tb: %0d distances (%0d saturated), %0d cycle restarts", distances, saturated,
             restarts);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
